// File: rtl/dpla_pkg.sv
package dpla_pkg;

  localparam int COLOR_W  = 8;
  localparam int BRIGHT_W = 8;
  localparam int LEVELS_W = 48;
  localparam int CNT_W    = 3;
  localparam int INDEX_W  = 6;
  localparam int CFG_IDX_W = 2;

  // Number of tail levels a released side walks through.
  localparam logic [CNT_W-1:0] TAIL_STEPS = 3'd6;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_TAIL_LEVELS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_COLOR  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_COLOR = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [LEVELS_W-1:0] TAIL_LEVELS_RST = 48'h01020202020A;
  localparam logic [COLOR_W-1:0]  LEFT_COLOR_RST  = 8'd1;
  localparam logic [COLOR_W-1:0]  RIGHT_COLOR_RST = 8'd2;

  // One entry of a pixel line.
  typedef struct packed {
    logic [COLOR_W-1:0]  color;
    logic [BRIGHT_W-1:0] bright;
  } pix_t;

  localparam int PIX_W = $bits(pix_t);

  // New head entry of one side and its updated tail count.
  typedef struct packed {
    pix_t             pix;
    logic [CNT_W-1:0] count;
  } ins_t;

  // Tail brightness level k; levels past the last one read as zero.
  function automatic logic [BRIGHT_W-1:0] tail_level(input logic [LEVELS_W-1:0] levels,
                                                     input logic [CNT_W-1:0] k);
    logic [BRIGHT_W-1:0] lvl;
    case (k)
      3'd0:    lvl = levels[7:0];
      3'd1:    lvl = levels[15:8];
      3'd2:    lvl = levels[23:16];
      3'd3:    lvl = levels[31:24];
      3'd4:    lvl = levels[39:32];
      3'd5:    lvl = levels[47:40];
      default: lvl = '0;
    endcase
    return lvl;
  endfunction

endpackage

// File: rtl/dpla_ram.sv
module dpla_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One write port, one registered read port; read data holds while re is low.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/dpla_insert.sv
module dpla_insert (
  input  logic                            held,
  input  logic [dpla_pkg::CNT_W-1:0]      count,
  input  logic [dpla_pkg::COLOR_W-1:0]    color,
  input  logic [dpla_pkg::LEVELS_W-1:0]   levels,
  output dpla_pkg::ins_t                  ins
);

  // A held side writes its color at level 0, a released side walks down the
  // tail and counts up, and an exhausted tail writes a blank pixel.
  always_comb begin
    ins.count = count;
    if (held) begin
      ins.pix.color  = color;
      ins.pix.bright = dpla_pkg::tail_level(levels, '0);
    end else if (count < dpla_pkg::TAIL_STEPS) begin
      ins.pix.color  = color;
      ins.pix.bright = dpla_pkg::tail_level(levels, count);
      ins.count      = count + 1'b1;
    end else begin
      ins.pix.color  = '0;
      ins.pix.bright = '0;
    end
  end

endmodule

// File: rtl/dual_pulse_led_strip_animator.sv
// Dual pulse LED strip animator. Each input beat applies its hold toggles and
// tail restarts at once; a beat with advance set also shifts both pixel lines
// and then streams the whole strip out as PIXELS result beats, positions 0 to
// PIXELS-1, with last_pixel on the final one. The lines live in two RAMs used
// as circular buffers around a shared head pointer, so a shift is a single
// write; the frame is then read one pixel per cycle while the output is not
// stalled, one read port per line. Reads pass a read data stage and an output
// register, and the next input beat is taken once the last pixel read of the
// current frame has been issued. Beats without advance produce no result.
// Reset clears the lines at once through per-entry valid bits, so no clearing
// pass is needed. Configuration writes are always taken and must happen only
// while the block is idle.
module dual_pulse_led_strip_animator #(
  parameter int PIXELS = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,

  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_toggle_left,
  input  logic                                in_toggle_right,
  input  logic                                in_restart_left,
  input  logic                                in_restart_right,
  input  logic                                in_advance,

  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [dpla_pkg::INDEX_W-1:0]        out_pixel_index,
  output logic [dpla_pkg::COLOR_W-1:0]        out_pixel_color,
  output logic [dpla_pkg::BRIGHT_W-1:0]       out_pixel_brightness,
  output logic                                out_last_pixel,

  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [dpla_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dpla_pkg::LEVELS_W-1:0]       cfg_data
);

  localparam int AW = $clog2(PIXELS);
  localparam logic [AW-1:0] LAST_ADDR = AW'(PIXELS - 1);

  typedef enum logic {
    ST_IDLE,
    ST_ISSUE
  } state_t;

  // Configuration registers.
  logic [dpla_pkg::LEVELS_W-1:0] tail_levels_r;
  logic [dpla_pkg::COLOR_W-1:0]  left_color_r;
  logic [dpla_pkg::COLOR_W-1:0]  right_color_r;

  // Side state.
  logic                       hold_left_r, hold_right_r;
  logic [dpla_pkg::CNT_W-1:0] left_cnt_r, right_cnt_r;

  // Line storage bookkeeping.
  logic [AW-1:0]     head_r;
  logic [PIXELS-1:0] line_vld_r;

  // Read issue.
  state_t        state_r;
  logic [AW-1:0] cnt_r;
  logic [AW-1:0] fa_r, ba_r;

  // Read data stage.
  logic          s1_v_r;
  logic [AW-1:0] s1_idx_r;
  logic          s1_last_r;
  logic          s1_vf_r, s1_vb_r;

  // Output register.
  logic                            out_valid_r;
  logic [AW-1:0]                   out_idx_r;
  logic [dpla_pkg::COLOR_W-1:0]    out_color_r;
  logic [dpla_pkg::BRIGHT_W-1:0]   out_bright_r;
  logic                            out_last_r;

  logic                       in_fire, adv_fire;
  logic                       hold_left_nxt, hold_right_nxt;
  logic [dpla_pkg::CNT_W-1:0] left_cnt_eff, right_cnt_eff;
  logic [AW-1:0]              head_nxt, ba_start;
  dpla_pkg::ins_t             ins_left, ins_right;
  logic                       s2_load, issue;
  dpla_pkg::pix_t             fwd_rd, bwd_rd, fwd_pix, bwd_pix;
  logic [dpla_pkg::COLOR_W:0] csum, pair;
  logic [dpla_pkg::BRIGHT_W-1:0] bright_nxt;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign adv_fire  = in_fire && in_advance;
  assign cfg_ready = 1'b1;

  // Toggles and restarts take effect before the insert.
  assign hold_left_nxt  = hold_left_r ^ in_toggle_left;
  assign hold_right_nxt = hold_right_r ^ in_toggle_right;
  assign left_cnt_eff   = in_restart_left ? '0 : left_cnt_r;
  assign right_cnt_eff  = in_restart_right ? '0 : right_cnt_r;

  dpla_insert u_ins_left (
    .held   (hold_left_nxt),
    .count  (left_cnt_eff),
    .color  (left_color_r),
    .levels (tail_levels_r),
    .ins    (ins_left)
  );

  dpla_insert u_ins_right (
    .held   (hold_right_nxt),
    .count  (right_cnt_eff),
    .color  (right_color_r),
    .levels (tail_levels_r),
    .ins    (ins_right)
  );

  // A shift moves the head forward; forward pixel i sits at head-i and
  // backward pixel PIXELS-1-i at head+1+i, both modulo PIXELS.
  assign head_nxt = (head_r == LAST_ADDR) ? '0 : head_r + AW'(1);
  assign ba_start = (head_nxt == LAST_ADDR) ? '0 : head_nxt + AW'(1);

  // Pipeline moves: output register, read data stage, read issue.
  assign s2_load = s1_v_r && (!out_valid_r || out_ready);
  assign issue   = (state_r == ST_ISSUE) && (!s1_v_r || s2_load);

  dpla_ram #(
    .WIDTH (dpla_pkg::PIX_W),
    .DEPTH (PIXELS)
  ) u_fwd_ram (
    .clk   (clk),
    .we    (adv_fire),
    .waddr (head_nxt),
    .wdata (ins_left.pix),
    .re    (issue),
    .raddr (fa_r),
    .rdata (fwd_rd)
  );

  dpla_ram #(
    .WIDTH (dpla_pkg::PIX_W),
    .DEPTH (PIXELS)
  ) u_bwd_ram (
    .clk   (clk),
    .we    (adv_fire),
    .waddr (head_nxt),
    .wdata (ins_right.pix),
    .re    (issue),
    .raddr (ba_r),
    .rdata (bwd_rd)
  );

  // Entries never written since reset read as blank.
  assign fwd_pix = s1_vf_r ? fwd_rd : '0;
  assign bwd_pix = s1_vb_r ? bwd_rd : '0;

  // Overlap of both pulse colors shows at full tail level 0.
  assign csum = {1'b0, fwd_pix.color} + {1'b0, bwd_pix.color};
  assign pair = {1'b0, left_color_r} + {1'b0, right_color_r};
  assign bright_nxt = (csum == pair) ? dpla_pkg::tail_level(tail_levels_r, '0)
                                     : fwd_pix.bright + bwd_pix.bright;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tail_levels_r <= dpla_pkg::TAIL_LEVELS_RST;
      left_color_r  <= dpla_pkg::LEFT_COLOR_RST;
      right_color_r <= dpla_pkg::RIGHT_COLOR_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        dpla_pkg::REG_TAIL_LEVELS: tail_levels_r <= cfg_data;
        dpla_pkg::REG_LEFT_COLOR:  left_color_r  <= cfg_data[dpla_pkg::COLOR_W-1:0];
        dpla_pkg::REG_RIGHT_COLOR: right_color_r <= cfg_data[dpla_pkg::COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  // Hold flags, tail counts, head pointer and line valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_left_r  <= 1'b0;
      hold_right_r <= 1'b0;
      left_cnt_r   <= '0;
      right_cnt_r  <= '0;
      head_r       <= '0;
      line_vld_r   <= '0;
    end else if (in_fire) begin
      hold_left_r  <= hold_left_nxt;
      hold_right_r <= hold_right_nxt;
      if (in_advance) begin
        left_cnt_r           <= ins_left.count;
        right_cnt_r          <= ins_right.count;
        head_r               <= head_nxt;
        line_vld_r[head_nxt] <= 1'b1;
      end else begin
        left_cnt_r  <= left_cnt_eff;
        right_cnt_r <= right_cnt_eff;
      end
    end
  end

  // Read issue sequencer: one pixel of each line per cycle while the pipeline is not stalled.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      fa_r    <= '0;
      ba_r    <= '0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (adv_fire) begin
            state_r <= ST_ISSUE;
            cnt_r   <= '0;
            fa_r    <= head_nxt;
            ba_r    <= ba_start;
          end
        end
        ST_ISSUE: begin
          if (issue) begin
            cnt_r <= cnt_r + AW'(1);
            fa_r  <= (fa_r == '0) ? LAST_ADDR : fa_r - AW'(1);
            ba_r  <= (ba_r == LAST_ADDR) ? '0 : ba_r + AW'(1);
            if (cnt_r == LAST_ADDR) begin
              state_r <= ST_IDLE;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // Read data stage: tags that travel with the RAM output.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (issue) begin
      s1_v_r <= 1'b1;
    end else if (s2_load) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_idx_r  <= cnt_r;
      s1_last_r <= (cnt_r == LAST_ADDR);
      s1_vf_r   <= line_vld_r[fa_r];
      s1_vb_r   <= line_vld_r[ba_r];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      out_idx_r    <= s1_idx_r;
      out_color_r  <= csum[dpla_pkg::COLOR_W-1:0];
      out_bright_r <= bright_nxt;
      out_last_r   <= s1_last_r;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_pixel_index      = dpla_pkg::INDEX_W'(out_idx_r);
  assign out_pixel_color      = out_color_r;
  assign out_pixel_brightness = out_bright_r;
  assign out_last_pixel       = out_last_r;

  // A frame starts its reads at pixel 0 right after the shift.
  a_frame_start: assert property (@(posedge clk) disable iff (!rst_n)
    adv_fire |=> (state_r == ST_ISSUE) && (cnt_r == '0))
    else $error("frame did not start at pixel 0");

  // The last pixel of a frame always carries the last strip position.
  a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && s1_last_r |-> (s1_idx_r == LAST_ADDR))
    else $error("last pixel tag on wrong position");

  // The forward read of a frame starts at the newest entry.
  a_addr_pair: assert property (@(posedge clk) disable iff (!rst_n)
    issue && (cnt_r == '0) |-> (fa_r == head_r))
    else $error("forward read does not start at head");

  // A stalled read data stage never takes a new read.
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && !s2_load |-> !issue)
    else $error("read issued into a full stage");

endmodule

// File: bench/dpla_frame_checker.sv
`timescale 1ns / 100ps

module dpla_frame_checker #(
  parameter int PIXELS = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,

  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic                           in_toggle_left,
  input  logic                           in_toggle_right,
  input  logic                           in_restart_left,
  input  logic                           in_restart_right,
  input  logic                           in_advance,

  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic [dpla_pkg::INDEX_W-1:0]   out_pixel_index,
  input  logic [dpla_pkg::COLOR_W-1:0]   out_pixel_color,
  input  logic [dpla_pkg::BRIGHT_W-1:0]  out_pixel_brightness,
  input  logic                           out_last_pixel,

  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [dpla_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dpla_pkg::LEVELS_W-1:0]  cfg_data,

  output int                             errors,
  output int                             pending,
  output int                             pixels_checked
);

  // One expected pixel beat of a frame.
  typedef struct {
    logic [dpla_pkg::INDEX_W-1:0]  index;
    logic [dpla_pkg::COLOR_W-1:0]  color;
    logic [dpla_pkg::BRIGHT_W-1:0] bright;
    logic                          last_pix;
  } pixel_beat_t;

  // Shadow copy of the strip state and the register file.
  dpla_pkg::pix_t                fwd_line [PIXELS];
  dpla_pkg::pix_t                bwd_line [PIXELS];
  logic                          left_held;
  logic                          right_held;
  logic [dpla_pkg::CNT_W-1:0]    left_count;
  logic [dpla_pkg::CNT_W-1:0]    right_count;
  logic [dpla_pkg::LEVELS_W-1:0] levels;
  logic [dpla_pkg::COLOR_W-1:0]  left_col;
  logic [dpla_pkg::COLOR_W-1:0]  right_col;

  pixel_beat_t         expected_pixels [$];
  int                  bad_count;
  int                  good_count;

  // Tail brightness for step k; steps past the end are dark.
  function automatic logic [dpla_pkg::BRIGHT_W-1:0] level_at(input int k);
    if (k >= int'(dpla_pkg::TAIL_STEPS)) return '0;
    return levels[8*k +: 8];
  endfunction

  // Entry that one side pushes into its line, with the updated tail count.
  function automatic dpla_pkg::ins_t next_head(input logic held,
                                               input logic [dpla_pkg::COLOR_W-1:0] col,
                                               input logic [dpla_pkg::CNT_W-1:0] count);
    dpla_pkg::ins_t head;
    head.count = count;
    if (held) begin
      head.pix.color  = col;
      head.pix.bright = level_at(0);
    end else if (count < dpla_pkg::TAIL_STEPS) begin
      head.pix.color  = col;
      head.pix.bright = level_at(int'(count));
      head.count      = count + 1'b1;
    end else begin
      head.pix = '0;
    end
    return head;
  endfunction

  // Shift both lines, insert the new heads and queue the rendered frame.
  task automatic shift_and_render();
    dpla_pkg::ins_t             fwd_head;
    dpla_pkg::ins_t             bwd_head;
    dpla_pkg::pix_t             a;
    dpla_pkg::pix_t             b;
    logic [dpla_pkg::COLOR_W:0] pair;
    logic [dpla_pkg::COLOR_W:0] csum;
    pixel_beat_t                beat;
    int                         i;
    fwd_head = next_head(left_held, left_col, left_count);
    bwd_head = next_head(right_held, right_col, right_count);
    for (i = PIXELS - 1; i > 0; i--) begin
      fwd_line[i] = fwd_line[i-1];
      bwd_line[i] = bwd_line[i-1];
    end
    fwd_line[0] = fwd_head.pix;
    bwd_line[0] = bwd_head.pix;
    left_count  = fwd_head.count;
    right_count = bwd_head.count;

    // The backward line is read in reverse; overlap is judged on the unwrapped sum.
    pair = {1'b0, left_col} + {1'b0, right_col};
    for (i = 0; i < PIXELS; i++) begin
      a = fwd_line[i];
      b = bwd_line[PIXELS-1-i];
      csum = {1'b0, a.color} + {1'b0, b.color};
      beat.index    = dpla_pkg::INDEX_W'(i);
      beat.color    = csum[dpla_pkg::COLOR_W-1:0];
      beat.bright   = (csum == pair) ? level_at(0)
                                     : dpla_pkg::BRIGHT_W'(a.bright + b.bright);
      beat.last_pix = (i == PIXELS - 1);
      expected_pixels.push_back(beat);
    end
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      bad_count++;
    end
  endtask

  // Watch all three channels on the rising edge.
  always @(posedge clk) begin
    pixel_beat_t want;
    if (!rst_n) begin
      foreach (fwd_line[i]) begin
        fwd_line[i] = '0;
        bwd_line[i] = '0;
      end
      left_held   = 1'b0;
      right_held  = 1'b0;
      left_count  = '0;
      right_count = '0;
      levels      = dpla_pkg::TAIL_LEVELS_RST;
      left_col    = dpla_pkg::LEFT_COLOR_RST;
      right_col   = dpla_pkg::RIGHT_COLOR_RST;
      expected_pixels.delete();
      bad_count   = 0;
      good_count  = 0;
    end else begin
      // Result beats are matched before this edge's input beat is queued.
      if (out_valid && out_ready) begin
        if (expected_pixels.size() == 0) begin
          $error("pixel beat with no frame pending: index %0d", out_pixel_index);
          bad_count++;
        end else begin
          want = expected_pixels.pop_front();
          check_field("pixel_index", 32'(want.index), 32'(out_pixel_index));
          check_field("pixel_color", 32'(want.color), 32'(out_pixel_color));
          check_field("pixel_brightness", 32'(want.bright), 32'(out_pixel_brightness));
          check_field("last_pixel", 32'(want.last_pix), 32'(out_last_pixel));
          good_count++;
        end
      end

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          dpla_pkg::REG_TAIL_LEVELS: levels    = cfg_data;
          dpla_pkg::REG_LEFT_COLOR:  left_col  = cfg_data[dpla_pkg::COLOR_W-1:0];
          dpla_pkg::REG_RIGHT_COLOR: right_col = cfg_data[dpla_pkg::COLOR_W-1:0];
          default: ;
        endcase
      end

      // Toggles and restarts apply whether or not the beat advances.
      if (in_valid && in_ready) begin
        if (in_toggle_left)   left_held   = !left_held;
        if (in_toggle_right)  right_held  = !right_held;
        if (in_restart_left)  left_count  = '0;
        if (in_restart_right) right_count = '0;
        if (in_advance) shift_and_render();
      end
    end
    errors         <= bad_count;
    pending        <= expected_pixels.size();
    pixels_checked <= good_count;
  end

endmodule

// File: bench/tb_dual_pulse_led_strip_animator.sv
`timescale 1ns / 100ps

module tb_dual_pulse_led_strip_animator;

  localparam int PIXELS = 32;
  // Drain time after the last pixel: a full frame plus pipeline slack.
  localparam int SETTLE = PIXELS + 8;
  // Index with no register behind it; writes there are dropped.
  localparam logic [dpla_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  typedef enum int {RX_OPEN, RX_RANDOM, RX_PATTERN, RX_SPARSE} rx_mode_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;

  logic                           in_valid = 1'b0;
  logic                           in_ready;
  logic                           in_toggle_left = 1'b0;
  logic                           in_toggle_right = 1'b0;
  logic                           in_restart_left = 1'b0;
  logic                           in_restart_right = 1'b0;
  logic                           in_advance = 1'b0;

  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic [dpla_pkg::INDEX_W-1:0]   out_pixel_index;
  logic [dpla_pkg::COLOR_W-1:0]   out_pixel_color;
  logic [dpla_pkg::BRIGHT_W-1:0]  out_pixel_brightness;
  logic                           out_last_pixel;

  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [dpla_pkg::CFG_IDX_W-1:0] cfg_index = dpla_pkg::REG_TAIL_LEVELS;
  logic [dpla_pkg::LEVELS_W-1:0]  cfg_data = '0;

  int                   errors;
  int                   pending;
  int                   pixels_checked;
  rx_mode_t             rx_mode = RX_OPEN;
  int                   rx_tick = 0;
  int                   beats_sent = 0;
  int                   frames_sent = 0;
  int                   settings_used = 1;

  dual_pulse_led_strip_animator #(.PIXELS(PIXELS)) dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_toggle_left       (in_toggle_left),
    .in_toggle_right      (in_toggle_right),
    .in_restart_left      (in_restart_left),
    .in_restart_right     (in_restart_right),
    .in_advance           (in_advance),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_pixel_index      (out_pixel_index),
    .out_pixel_color      (out_pixel_color),
    .out_pixel_brightness (out_pixel_brightness),
    .out_last_pixel       (out_last_pixel),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data)
  );

  dpla_frame_checker #(.PIXELS(PIXELS)) frame_check (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_toggle_left       (in_toggle_left),
    .in_toggle_right      (in_toggle_right),
    .in_restart_left      (in_restart_left),
    .in_restart_right     (in_restart_right),
    .in_advance           (in_advance),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_pixel_index      (out_pixel_index),
    .out_pixel_color      (out_pixel_color),
    .out_pixel_brightness (out_pixel_brightness),
    .out_last_pixel       (out_last_pixel),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .errors               (errors),
    .pending              (pending),
    .pixels_checked       (pixels_checked)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // The receiver stalls according to the mode of the current phase.
  always @(posedge clk) begin
    rx_tick <= rx_tick + 1;
    case (rx_mode)
      RX_OPEN:    out_ready <= 1'b1;
      RX_RANDOM:  out_ready <= ($urandom_range(0, 3) != 0);
      RX_PATTERN: out_ready <= ((rx_tick % 11) < 6);
      default:    out_ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // Present one input beat and hold it until the block takes it.
  task automatic send_beat(input logic tl, input logic tr, input logic rl,
                           input logic rr, input logic adv);
    in_valid         <= 1'b1;
    in_toggle_left   <= tl;
    in_toggle_right  <= tr;
    in_restart_left  <= rl;
    in_restart_right <= rr;
    in_advance       <= adv;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    beats_sent++;
    if (adv) frames_sent++;
  endtask

  // Bursts of beats with random gaps; some bursts launch a fresh pulse pair
  // and let it run, the rest carry random toggles and restarts.
  task automatic random_phase(input int n_beats, input int gap_limit);
    int  remaining;
    int  burst;
    int  gap;
    bit  fresh;
    bit  first;
    remaining = n_beats;
    while (remaining > 0) begin
      burst = $urandom_range(1, 10);
      fresh = ($urandom_range(0, 3) == 0);
      first = 1'b1;
      while (burst > 0 && remaining > 0) begin
        if (fresh)
          send_beat(1'b0, 1'b0, first, first, 1'b1);
        else
          send_beat($urandom_range(0, 9) == 0, $urandom_range(0, 9) == 0,
                    $urandom_range(0, 6) == 0, $urandom_range(0, 6) == 0,
                    $urandom_range(0, 3) != 0);
        first = 1'b0;
        burst--;
        remaining--;
      end
      gap = (gap_limit > 0) ? $urandom_range(0, gap_limit) : 0;
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Wait until every queued pixel has come out and the block has settled.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [dpla_pkg::CFG_IDX_W-1:0] idx,
                           input logic [dpla_pkg::LEVELS_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Load a full register setting while the block is idle.
  task automatic program_regs(input logic [dpla_pkg::LEVELS_W-1:0] lv,
                              input logic [dpla_pkg::COLOR_W-1:0] lc,
                              input logic [dpla_pkg::COLOR_W-1:0] rc, input bit spare);
    write_reg(dpla_pkg::REG_TAIL_LEVELS, lv);
    write_reg(dpla_pkg::REG_LEFT_COLOR,
              {{(dpla_pkg::LEVELS_W-dpla_pkg::COLOR_W){1'b1}}, lc});
    write_reg(dpla_pkg::REG_RIGHT_COLOR,
              {{(dpla_pkg::LEVELS_W-dpla_pkg::COLOR_W){1'b0}}, rc});
    if (spare) write_reg(REG_SPARE, {16'($urandom), $urandom});
    cfg_valid <= 1'b0;
    @(posedge clk);
    settings_used++;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the tail out to exhaustion with both sides released.
    repeat (8) send_beat(1'b0, 1'b0, 1'b0, 1'b0, 1'b1);
    // Hold the left side without advancing, then advance while held.
    send_beat(1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
    send_beat(1'b0, 1'b0, 1'b0, 1'b0, 1'b1);
    // Toggle and restart together on the right side.
    send_beat(1'b0, 1'b1, 1'b0, 1'b1, 1'b1);
    repeat (3) send_beat(1'b0, 1'b0, 1'b0, 1'b0, 1'b1);
    // Everything at once releases both sides and restarts both tails.
    send_beat(1'b1, 1'b1, 1'b1, 1'b1, 1'b1);
    send_beat(1'b0, 1'b0, 1'b1, 1'b0, 1'b0);
    rx_mode <= RX_RANDOM;
    repeat (2) send_beat(1'b0, 1'b0, 1'b0, 1'b0, 1'b1);
    send_beat(1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    send_beat(1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
    repeat (3) send_beat(1'b0, 1'b0, 1'b0, 1'b0, 1'b1);

    // Reset setting under random stalls and gaps.
    random_phase(55, 5);
    drain();

    // All-ones setting: colors wrap, so overlap must use the unwrapped sum.
    program_regs({dpla_pkg::LEVELS_W{1'b1}}, 8'hFF, 8'hFF, 1'b0);
    rx_mode <= RX_PATTERN;
    random_phase(50, 0);
    drain();

    // All-zero levels, opposite color extremes and a dropped write.
    program_regs('0, 8'h00, 8'hFF, 1'b1);
    rx_mode <= RX_SPARSE;
    random_phase(40, 3);
    drain();

    program_regs({16'($urandom), $urandom}, 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)), 1'b0);
    rx_mode <= RX_OPEN;
    random_phase(50, 8);
    drain();

    program_regs({16'($urandom), $urandom}, 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)), 1'b1);
    rx_mode <= RX_RANDOM;
    random_phase(50, 2);
    drain();

    $display("Sent %0d input beats (%0d frames) over %0d register settings.",
             beats_sent, frames_sent, settings_used);
    $display("Checked %0d pixel beats under four receiver stall modes.", pixels_checked);
    if (errors == 0 && pending == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
